FILE: hdl/bpa_pkg.sv
// Package of the block pool allocator: payload structs, codes, state type and
// sizing constants. Depends on nothing; every other file of the block uses it.
package bpa_pkg;

   localparam int MAX_BLOCKS = 1024;
   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int BYTES_W = 17;
   localparam int OFFSET_W = 26;
   localparam int PROD_W = IDX_W + BYTES_W;

   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_BLOCKS);
   localparam logic [CNT_W-1:0] RESET_COUNT = CNT_W'(MAX_BLOCKS < 1024 ? MAX_BLOCKS : 1024);
   localparam logic [BYTES_W-1:0] MAX_BYTES = BYTES_W'(65536);
   localparam logic [BYTES_W-1:0] RESET_BYTES = BYTES_W'(64);

   localparam logic [1:0] REQ_ALLOC = 2'd0;
   localparam logic [1:0] REQ_FREE = 2'd1;
   localparam logic [1:0] REQ_QUERY = 2'd2;
   localparam logic [1:0] REQ_RESET = 2'd3;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_NOFREE = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   localparam logic [1:0] CSR_BLOCK_COUNT = 2'd0;
   localparam logic [1:0] CSR_BLOCK_BYTES = 2'd1;

   typedef struct packed {
      logic [1:0] req_type;
      logic [9:0] block_index;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] status;
      logic [9:0] granted_index;
      logic is_allocated;
      logic [25:0] block_offset;
      logic [10:0] free_count;
      logic [10:0] used_count;
   } rsp_payload_type;

   typedef struct packed {
      logic init;
      logic rd;
      logic pop;
      logic push;
      logic [IDX_W-1:0] push_data;
   } stack_cmd_type;

   typedef struct packed {
      logic [IDX_W-1:0] top;
      logic [CNT_W-1:0] depth;
      logic empty;
   } stack_stat_type;

   typedef enum logic [1:0] {
      STATE_CLEAR,
      STATE_IDLE,
      STATE_LOOK,
      STATE_MUL
   } state_type;

endpackage

FILE: hdl/bpa_flag_ram.sv
// Single-port memory of the per-block allocated flags with a registered read.
// Depends on bpa_pkg for the pool size.
module bpa_flag_ram (
   input  logic                      clock,
   input  logic [bpa_pkg::IDX_W-1:0] addr,
   input  logic                      we,
   input  logic                      wdata,
   output logic                      rdata
);

   logic mem [bpa_pkg::MAX_BLOCKS];
   logic rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end else begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/bpa_free_stack.sv
// LIFO stack of free block indices with its depth and a low-water mark. Entries
// below the mark were never written since the last pool reset and read as their
// initial value. Depends on bpa_pkg.
module bpa_free_stack (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [bpa_pkg::CNT_W-1:0] block_count,
   input  bpa_pkg::stack_cmd_type    cmd,
   output bpa_pkg::stack_stat_type   stat
);

   logic [bpa_pkg::IDX_W-1:0] mem [bpa_pkg::MAX_BLOCKS];
   logic [bpa_pkg::IDX_W-1:0] mem_q_ff;
   logic [bpa_pkg::IDX_W-1:0] rd_pos_ff;
   logic [bpa_pkg::CNT_W-1:0] depth_ff, depth_in;
   logic [bpa_pkg::CNT_W-1:0] mark_ff, mark_in;
   logic [bpa_pkg::CNT_W-1:0] below;
   logic [bpa_pkg::CNT_W-1:0] initial_value;
   logic                      push_ok;

   assign below = depth_ff - 1'b1;
   assign push_ok = cmd.push && (depth_ff != bpa_pkg::MAX_COUNT);
   assign initial_value = block_count - 1'b1 - {1'b0, rd_pos_ff};

   always_comb begin
      depth_in = depth_ff;
      mark_in = mark_ff;
      if (cmd.init) begin
         depth_in = block_count;
         mark_in = block_count;
      end else if (cmd.pop) begin
         depth_in = below;
         if (below < mark_ff) begin
            mark_in = below;
         end
      end else if (push_ok) begin
         depth_in = depth_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= bpa_pkg::RESET_COUNT;
         mark_ff <= bpa_pkg::RESET_COUNT;
      end else begin
         depth_ff <= depth_in;
         mark_ff <= mark_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok && !cmd.init) begin
         mem[depth_ff[bpa_pkg::IDX_W-1:0]] <= cmd.push_data;
      end
      if (cmd.rd) begin
         mem_q_ff <= mem[below[bpa_pkg::IDX_W-1:0]];
         rd_pos_ff <= below[bpa_pkg::IDX_W-1:0];
      end
   end

   always_comb begin
      stat.depth = depth_ff;
      stat.empty = (depth_ff == '0);
      if ({1'b0, rd_pos_ff} < mark_ff) begin
         stat.top = initial_value[bpa_pkg::IDX_W-1:0];
      end else begin
         stat.top = mem_q_ff;
      end
   end

endmodule

FILE: hdl/block_pool_allocator_unit.sv
// Top level of the block pool allocator: request sequencer, flag clearing pass,
// offset multiplier and result register. Depends on bpa_pkg, bpa_flag_ram and
// bpa_free_stack.
//
// An item is taken when start is high and busy is low. The stack and flag
// memories are read as it is taken, STATE_LOOK uses the registered data, and
// STATE_MUL registers the result and offset product, shown on rsp_payload for
// one cycle with rsp_valid; busy is high in both states, so a new item is taken
// only once the last is through. A pool reset item, a block_count write and the
// hardware reset clear the first block_count flag entries (1024 after hardware
// reset) with busy high; a pool reset item then gives its result via STATE_MUL.
// The receiver cannot stall results. Configuration writes are always ready.
module block_pool_allocator_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  bpa_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   output bpa_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [16:0]              csr_data
);

   bpa_pkg::state_type              state_ff, state_in;
   logic [bpa_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic                            pend_ff, pend_in;
   logic [bpa_pkg::CNT_W-1:0]       bc_ff, bc_in;
   logic [bpa_pkg::BYTES_W-1:0]     bb_ff, bb_in;
   bpa_pkg::req_payload_type        req_ff, req_in;
   logic [bpa_pkg::IDX_W-1:0]       grant_ff, grant_in;
   logic [1:0]                      status_ff, status_in;
   logic                            flag_ff, flag_in;
   logic                            show_ff, show_in;
   logic                            rsp_valid_ff;
   bpa_pkg::rsp_payload_type        rsp_ff;

   logic [bpa_pkg::IDX_W-1:0]       ram_addr;
   logic                            ram_we;
   logic                            ram_wdata;
   logic                            ram_rdata;
   bpa_pkg::stack_cmd_type          stack_cmd;
   bpa_pkg::stack_stat_type         stack_stat;
   logic                            in_range;
   logic [bpa_pkg::CNT_W-1:0]       bc_wr;
   logic [bpa_pkg::BYTES_W-1:0]     bb_wr;
   logic [bpa_pkg::PROD_W-1:0]      product;

   bpa_flag_ram u_flag_ram (
      .clock (clock),
      .addr  (ram_addr),
      .we    (ram_we),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   bpa_free_stack u_free_stack (
      .clock       (clock),
      .reset       (reset),
      .block_count (bc_ff),
      .cmd         (stack_cmd),
      .stat        (stack_stat)
   );

   assign busy = (state_ff != bpa_pkg::STATE_IDLE);
   assign csr_ready = 1'b1;
   assign in_range = ({1'b0, req_ff.block_index} < bc_ff);
   assign product = bpa_pkg::PROD_W'(grant_ff) * bpa_pkg::PROD_W'(bb_ff);

   always_comb begin
      bc_wr = csr_data[bpa_pkg::CNT_W-1:0];
      if (bc_wr == '0) begin
         bc_wr = bpa_pkg::CNT_W'(1);
      end else if (bc_wr > bpa_pkg::MAX_COUNT) begin
         bc_wr = bpa_pkg::MAX_COUNT;
      end
      bb_wr = csr_data;
      if (bb_wr == '0) begin
         bb_wr = bpa_pkg::BYTES_W'(1);
      end else if (bb_wr > bpa_pkg::MAX_BYTES) begin
         bb_wr = bpa_pkg::MAX_BYTES;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      pend_in = pend_ff;
      bc_in = bc_ff;
      bb_in = bb_ff;
      req_in = req_ff;
      grant_in = grant_ff;
      status_in = status_ff;
      flag_in = flag_ff;
      show_in = show_ff;
      stack_cmd = '0;
      ram_addr = req_payload.block_index;
      ram_we = 1'b0;
      ram_wdata = 1'b0;
      unique case (state_ff)
         bpa_pkg::STATE_CLEAR: begin
            ram_we = 1'b1;
            ram_addr = cnt_ff[bpa_pkg::IDX_W-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == bc_ff - 1'b1) begin
               stack_cmd.init = 1'b1;
               cnt_in = '0;
               pend_in = 1'b0;
               if (pend_ff) begin
                  state_in = bpa_pkg::STATE_MUL;
                  status_in = bpa_pkg::STATUS_OK;
                  grant_in = '0;
                  flag_in = 1'b0;
                  show_in = 1'b0;
               end else begin
                  state_in = bpa_pkg::STATE_IDLE;
               end
            end
         end
         bpa_pkg::STATE_IDLE: begin
            if (start) begin
               req_in = req_payload;
               if (req_payload.req_type == bpa_pkg::REQ_RESET) begin
                  state_in = bpa_pkg::STATE_CLEAR;
                  cnt_in = '0;
                  pend_in = 1'b1;
               end else begin
                  state_in = bpa_pkg::STATE_LOOK;
                  stack_cmd.rd = 1'b1;
               end
            end
         end
         bpa_pkg::STATE_LOOK: begin
            state_in = bpa_pkg::STATE_MUL;
            grant_in = req_ff.block_index;
            status_in = bpa_pkg::STATUS_OK;
            flag_in = in_range && ram_rdata;
            show_in = in_range;
            case (req_ff.req_type)
               bpa_pkg::REQ_ALLOC: begin
                  if (stack_stat.empty) begin
                     status_in = bpa_pkg::STATUS_NOFREE;
                     grant_in = '0;
                     flag_in = 1'b0;
                     show_in = 1'b0;
                  end else begin
                     stack_cmd.pop = 1'b1;
                     grant_in = stack_stat.top;
                     ram_we = 1'b1;
                     ram_addr = stack_stat.top;
                     ram_wdata = 1'b1;
                     flag_in = 1'b1;
                     show_in = 1'b1;
                  end
               end
               bpa_pkg::REQ_FREE: begin
                  if (!in_range || !ram_rdata) begin
                     status_in = bpa_pkg::STATUS_INVALID;
                  end else begin
                     ram_we = 1'b1;
                     ram_addr = req_ff.block_index;
                     ram_wdata = 1'b0;
                     stack_cmd.push = 1'b1;
                     stack_cmd.push_data = req_ff.block_index;
                     flag_in = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
         bpa_pkg::STATE_MUL: begin
            state_in = bpa_pkg::STATE_IDLE;
         end
         default: begin
            state_in = bpa_pkg::STATE_IDLE;
         end
      endcase
      if (csr_valid) begin
         unique case (csr_index)
            bpa_pkg::CSR_BLOCK_COUNT: begin
               bc_in = bc_wr;
               state_in = bpa_pkg::STATE_CLEAR;
               cnt_in = '0;
            end
            bpa_pkg::CSR_BLOCK_BYTES: begin
               bb_in = bb_wr;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpa_pkg::STATE_CLEAR;
         cnt_ff <= '0;
         pend_ff <= 1'b0;
         bc_ff <= bpa_pkg::RESET_COUNT;
         bb_ff <= bpa_pkg::RESET_BYTES;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         pend_ff <= pend_in;
         bc_ff <= bc_in;
         bb_ff <= bb_in;
         rsp_valid_ff <= (state_ff == bpa_pkg::STATE_MUL);
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      grant_ff <= grant_in;
      status_ff <= status_in;
      flag_ff <= flag_in;
      show_ff <= show_in;
      if (state_ff == bpa_pkg::STATE_MUL) begin
         rsp_ff.status <= status_ff;
         rsp_ff.granted_index <= grant_ff;
         rsp_ff.is_allocated <= flag_ff;
         rsp_ff.block_offset <= show_ff ? product[bpa_pkg::OFFSET_W-1:0] : '0;
         rsp_ff.free_count <= stack_stat.depth;
         rsp_ff.used_count <= bc_ff - stack_stat.depth;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_no_quick_result : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result strobe one cycle after an item was taken");

   a_free_bounded : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.free_count <= bc_ff))
      else $error("free count above block count");

   a_nofree_empty : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == bpa_pkg::STATUS_NOFREE)
         |-> (rsp_payload.free_count == '0))
      else $error("no-free status while blocks remain free");

endmodule
